// ===== rtl/fbfl_pkg.sv =====
// fbfl_pkg: shared types, codes and constants of the fixed block free list
// used by the divider, the allocator top and its checker
// no dependencies
package fbfl_pkg;

    localparam int BASE_W     = 32;
    localparam int SIZE_W     = 25;
    localparam int TOTAL_W    = 9;
    localparam int ADDR_W     = 40;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_MAX_BLOCKS = 256;

    localparam logic [BASE_W-1:0]  BASE_RESET  = '0;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(65536);
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(256);

    typedef enum logic [0:0] {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK            = 3'd0,
        STAT_POOL_EMPTY    = 3'd1,
        STAT_SIZE_TOO_BIG  = 3'd2,
        STAT_BELOW_BASE    = 3'd3,
        STAT_OFF_BOUNDARY  = 3'd4,
        STAT_BEYOND_POOL   = 3'd5,
        STAT_STACK_FULL    = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_SIZE  = 2'd1,
        CFG_TOTAL = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_ALLOC_RD,
        ST_ALLOC_ADD,
        ST_RELEASE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t                 operation;
        logic [SIZE_W-1:0]   request_size;
        logic [ADDR_W-1:0]   release_address;
    } fbfl_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   block_address;
        status_t             status;
        logic [COUNT_W-1:0]  free_count;
    } fbfl_out_t;

    // divider result seen by the control logic
    typedef struct packed {
        logic                done;
        logic [ADDR_W-1:0]   quot;
        logic [SIZE_W-1:0]   rem;
    } div_res_t;

endpackage

// ===== rtl/fbfl_ram.sv =====
// fbfl_ram: generic single write port, single read port ram, registered read
// depends on nothing; width and depth come from parameters
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fbfl_div.sv =====
// fbfl_div: restoring divider, one quotient bit per cycle
// depends on fbfl_pkg for widths and the result struct
module fbfl_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fbfl_pkg::ADDR_W-1:0] dividend,
    input  logic [fbfl_pkg::SIZE_W-1:0] divisor,
    output fbfl_pkg::div_res_t          result
);
    import fbfl_pkg::*;

    localparam int STEP_W = $clog2(ADDR_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   quot_reg, quot_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    logic [SIZE_W-1:0]   dvs_reg, dvs_next;

    logic [SIZE_W:0]     shifted;
    logic [SIZE_W:0]     diff;
    logic                fits;

    always_comb
    begin
        shifted = {rem_reg, quot_reg[ADDR_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(ADDR_W - 1);
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // dividend shifts out of the top while quotient bits enter below
            rem_next  = fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
            quot_next = {quot_reg[ADDR_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign result.done = done_reg;
    assign result.quot = quot_reg;
    assign result.rem  = rem_reg;

endmodule

// ===== rtl/fixed_block_free_list.sv =====
// fixed_block_free_list: lifo free list of block indices held in one ram
// allocate: the result passes a ram read, a multiply and an add before it is registered at the output
// release: the result waits on the 40-step serial divide of the offset
// one item at a time, allocate or release; the next input is taken while a result waits
// reset and every configuration write to a known register restore a full stack at once, no clearing pass
// depends on fbfl_pkg, fbfl_ram and fbfl_div
module fixed_block_free_list #(
    parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  fbfl_pkg::fbfl_in_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output fbfl_pkg::fbfl_out_t             out_data,
    input  logic                            cfg_write,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fbfl_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W  = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam int PROD_W = IDX_W + SIZE_W;

    function automatic logic [CNT_W-1:0] eff_total_f(input logic [TOTAL_W-1:0] total);
        logic [CMP_W-1:0] t;
        logic [CMP_W-1:0] m;
        logic [CMP_W-1:0] e;
        t = CMP_W'(total);
        m = CMP_W'(MAX_BLOCKS);
        e = (t > m) ? m : t;
        return e[CNT_W-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [BASE_W-1:0]    base_reg, base_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    // depth of the stack and the lowest depth seen since the last refill:
    // entries below the mark were never written and still hold their own index
    logic [CNT_W-1:0]     depth_reg, depth_next;
    logic [CNT_W-1:0]     mark_reg, mark_next;
    fbfl_in_t             item_reg, item_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    fbfl_out_t            res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    fbfl_out_t            out_data_reg, out_data_next;

    logic [SIZE_W-1:0]    eff_size;
    logic [CNT_W-1:0]     eff_total;
    logic                 size_too_big;
    logic                 below_base;
    logic [ADDR_W-1:0]    offset;
    logic                 alloc_ok;
    logic                 rel_ok;
    logic [IDX_W-1:0]     idx_sel;
    logic                 out_free;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [IDX_W-1:0]     ram_rdata;
    logic                 div_start;
    div_res_t             div_res;

    fbfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fbfl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (offset),
        .divisor  (eff_size),
        .result   (div_res)
    );

    always_comb
    begin
        eff_size     = (size_reg == '0) ? SIZE_W'(1) : size_reg;
        eff_total    = eff_total_f(total_reg);
        size_too_big = item_reg.request_size > eff_size;
        below_base   = item_reg.release_address < ADDR_W'(base_reg);
        offset       = item_reg.release_address - ADDR_W'(base_reg);
        alloc_ok     = !size_too_big && (depth_reg != '0);
        rel_ok       = (div_res.rem == '0) && (div_res.quot < ADDR_W'(eff_total))
                       && (depth_reg < eff_total);
        idx_sel      = (depth_reg < mark_reg) ? depth_reg[IDX_W-1:0] : ram_rdata;
        out_free     = !out_valid_reg || out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_data.operation == OP_ALLOC) ? ST_ALLOC : ST_RELEASE;
                end
            end
            ST_ALLOC:
            begin
                state_next = alloc_ok ? ST_ALLOC_RD : ST_DONE;
            end
            ST_ALLOC_RD:
            begin
                state_next = ST_ALLOC_ADD;
            end
            ST_ALLOC_ADD:
            begin
                state_next = ST_DONE;
            end
            ST_RELEASE:
            begin
                state_next = below_base ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the control
    always_comb
    begin
        in_ready  = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        ram_raddr = depth_reg[IDX_W-1:0] - IDX_W'(1);
        ram_waddr = depth_reg[IDX_W-1:0];
        ram_wdata = div_res.quot[IDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_ALLOC:
            begin
                ram_re = alloc_ok;
            end
            ST_RELEASE:
            begin
                div_start = !below_base;
            end
            ST_DIV:
            begin
                ram_we = div_res.done && rel_ok;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath and configuration
    always_comb
    begin
        base_next      = base_reg;
        size_next      = size_reg;
        total_next     = total_reg;
        depth_next     = depth_reg;
        mark_next      = mark_reg;
        item_next      = item_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                item_next = in_data;
            end
            ST_ALLOC:
            begin
                res_next.block_address = '0;
                res_next.status        = STAT_OK;
                res_next.free_count    = '0;
                if (size_too_big)
                begin
                    res_next.status = STAT_SIZE_TOO_BIG;
                end
                else if (depth_reg == '0)
                begin
                    res_next.status = STAT_POOL_EMPTY;
                end
                else
                begin
                    depth_next = depth_reg - CNT_W'(1);
                end
            end
            ST_ALLOC_RD:
            begin
                if (depth_reg < mark_reg)
                begin
                    mark_next = depth_reg;
                end
                prod_next = PROD_W'(idx_sel) * PROD_W'(eff_size);
            end
            ST_ALLOC_ADD:
            begin
                res_next.block_address = ADDR_W'(base_reg) + ADDR_W'(prod_reg);
            end
            ST_RELEASE:
            begin
                res_next.block_address = '0;
                res_next.status        = below_base ? STAT_BELOW_BASE : STAT_OK;
                res_next.free_count    = '0;
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    if (div_res.rem != '0)
                    begin
                        res_next.status = STAT_OFF_BOUNDARY;
                    end
                    else if (div_res.quot >= ADDR_W'(eff_total))
                    begin
                        res_next.status = STAT_BEYOND_POOL;
                    end
                    else if (depth_reg >= eff_total)
                    begin
                        res_next.status = STAT_STACK_FULL;
                    end
                    else
                    begin
                        depth_next = depth_reg + CNT_W'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.block_address = res_reg.block_address;
                    out_data_next.status        = res_reg.status;
                    out_data_next.free_count    = COUNT_W'(depth_reg);
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase

        // a write to a known register refills the stack
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_BASE:
                begin
                    base_next = cfg_data[BASE_W-1:0];
                end
                CFG_SIZE:
                begin
                    size_next = cfg_data[SIZE_W-1:0];
                end
                CFG_TOTAL:
                begin
                    total_next = cfg_data[TOTAL_W-1:0];
                end
                default:
                begin
                    base_next = base_reg;
                end
            endcase
            if (cfg_index == CFG_BASE || cfg_index == CFG_SIZE || cfg_index == CFG_TOTAL)
            begin
                depth_next = eff_total_f(total_next);
                mark_next  = eff_total_f(total_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= BASE_RESET;
            size_reg      <= SIZE_RESET;
            total_reg     <= TOTAL_RESET;
            depth_reg     <= eff_total_f(TOTAL_RESET);
            mark_reg      <= eff_total_f(TOTAL_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            size_reg      <= size_next;
            total_reg     <= total_next;
            depth_reg     <= depth_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/fbfl_checker.sv =====
// fbfl_checker: port level assertions on the free list allocator, bound to the top
// depends on fbfl_pkg and on the ports of fixed_block_free_list
module fbfl_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  fbfl_pkg::fbfl_out_t             out_data,
    input  logic                            cfg_write
);
    import fbfl_pkg::*;

    // a result that is not taken holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // only a successful allocate carries an address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STAT_OK |-> out_data.block_address == '0)
        else $error("failed item carries a block address");

    // an empty pool report leaves nothing free
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STAT_POOL_EMPTY |-> out_data.free_count == '0)
        else $error("pool empty reported with free blocks");

    // a double free is only seen on a stack that holds something
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STAT_STACK_FULL |-> out_data.free_count != '0)
        else $error("stack full reported on an empty stack");

    // one item at a time: the transfer cycle is followed by a busy cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !cfg_write |=> !in_ready)
        else $error("second input taken while an item is at work");

endmodule

bind fixed_block_free_list fbfl_checker u_fbfl_checker (.*);
